// ===== src/nfia_pkg.sv =====
// shared types and constants of the next-fit id allocator
package nfia_pkg;

  localparam int ID_SPACE_DEF   = 1024;
  localparam int SLOT_LIMIT_DEF = 64;

  localparam int ACT_W = 3;
  localparam int ST_W  = 3;
  localparam int ID_W  = 10;
  localparam int SEQ_W = 64;
  localparam int CNT_W = 11;

  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 80;

  localparam int WRAP_ID = 2;

  typedef enum logic [ACT_W-1:0] {
    ACT_RESERVE = 3'd0,
    ACT_RELEASE = 3'd1,
    ACT_ASSIGN  = 3'd2,
    ACT_REMOVE  = 3'd3,
    ACT_LOOKUP  = 3'd4
  } act_t;

  typedef enum logic [ST_W-1:0] {
    STAT_OK        = 3'd0,
    STAT_NO_SLOT   = 3'd1,
    STAT_UNDERFLOW = 3'd2,
    STAT_NO_FREE   = 3'd3,
    STAT_NOT_FOUND = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PROBE,
    S_DONE
  } state_t;

endpackage

// ===== src/nfia_map.sv =====
// in-use bitmap memory with one read port, one write port and a clearing pass after reset
module nfia_map #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic          rd_bit,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic          wr_bit,
  output logic          ready
);

  logic          mem [DEPTH];
  logic          clr_r;
  logic [AW-1:0] clr_idx_r;
  logic          rd_q_r;

  logic          w_en;
  logic [AW-1:0] w_addr;
  logic          w_bit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r     <= 1'b1;
      clr_idx_r <= '0;
    end else if (clr_r) begin
      if (clr_idx_r == AW'(DEPTH - 1)) begin
        clr_r <= 1'b0;
      end
      clr_idx_r <= clr_idx_r + AW'(1);
    end
  end

  always_comb begin
    if (clr_r) begin
      w_en   = 1'b1;
      w_addr = clr_idx_r;
      w_bit  = 1'b0;
    end else begin
      w_en   = wr_en;
      w_addr = wr_addr;
      w_bit  = wr_bit;
    end
  end

  always_ff @(posedge clk) begin
    if (w_en) begin
      mem[w_addr] <= w_bit;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  assign rd_bit = rd_q_r;
  assign ready  = !clr_r;

endmodule

// ===== src/next_fit_id_allocator_top.sv =====
// top level of the next-fit id allocator: action sequencer, counters and result register
//
//  channel | dir | ports           | content
//  in      | in  | in_t*           | tuser action, tdata id_in
//  out     | out | out_t*          | tdata status, id_out, sequence_out, present
//
//  reserve, release and unknown actions: S_IDLE to S_DONE, then out_tvalid and out_tdata are registered
//  remove and lookup: S_IDLE, S_PROBE, S_DONE, at most one bitmap read (none for an out-of-range id)
//  assign: S_IDLE, then S_PROBE for each entry probed (1 to ID_SPACE entries), then S_DONE
//  after reset the bitmap clearing pass runs over all ID_SPACE entries with in_tready low
//  one item in flight; a held result stalls only the finish of the next item
module next_fit_id_allocator_top
  import nfia_pkg::*;
#(
  parameter int ID_SPACE   = ID_SPACE_DEF,
  parameter int SLOT_LIMIT = SLOT_LIMIT_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // id_in[9:0]
  input  logic [ACT_W-1:0]      in_tuser,   // action[2:0]
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata   // status[2:0], id_out[12:3], sequence_out[76:13], present[77]
);

  localparam int IdW  = $clog2(ID_SPACE);
  localparam int CmpW = ((IdW > ID_W) ? IdW : ID_W) + 1;
  localparam logic [IdW:0]  SpaceC = (IdW+1)'(ID_SPACE);
  localparam logic [CmpW-1:0] SpaceCmp = CmpW'(ID_SPACE);

  state_t              state_r, state_nxt;
  act_t                act_r, act_nxt;
  logic [IdW-1:0]      cur_r, cur_nxt;
  logic [IdW-1:0]      cnt_r, cnt_nxt;
  logic                rng_r, rng_nxt;
  logic [IdW-1:0]      next_id_r, next_id_nxt;
  logic [SEQ_W-1:0]    seq_r, seq_nxt;
  logic [CNT_W-1:0]    rsv_r, rsv_nxt;
  logic [CNT_W-1:0]    reg_r, reg_nxt;

  status_t             res_status_r, res_status_nxt;
  logic [ID_W-1:0]     res_id_r, res_id_nxt;
  logic [SEQ_W-1:0]    res_seq_r, res_seq_nxt;
  logic                res_present_r, res_present_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  logic                map_rd_en;
  logic [IdW-1:0]      map_rd_addr;
  logic                map_rd_bit;
  logic                map_wr_en;
  logic [IdW-1:0]      map_wr_addr;
  logic                map_wr_bit;
  logic                map_ready;

  logic                in_xfer;
  logic [CmpW-1:0]     id_ext;
  logic                id_in_range;
  logic [IdW-1:0]      id_addr;
  logic [IdW-1:0]      start_id;
  logic [IdW-1:0]      cur_adv;
  logic [SEQ_W-1:0]    seq_inc;

  function automatic logic [IdW-1:0] adv_id(input logic [IdW-1:0] a);
    logic [IdW:0] n;
    n = {1'b0, a} + (IdW+1)'(1);
    if (n >= SpaceC) begin
      return IdW'(WRAP_ID);
    end
    return n[IdW-1:0];
  endfunction

  nfia_map #(
    .DEPTH (ID_SPACE),
    .AW    (IdW)
  ) u_map (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (map_rd_en),
    .rd_addr (map_rd_addr),
    .rd_bit  (map_rd_bit),
    .wr_en   (map_wr_en),
    .wr_addr (map_wr_addr),
    .wr_bit  (map_wr_bit),
    .ready   (map_ready)
  );

  assign in_tready   = (state_r == S_IDLE) && map_ready;
  assign in_xfer     = in_tvalid && in_tready;
  assign id_ext      = CmpW'(in_tdata[ID_W-1:0]);
  assign id_in_range = id_ext < SpaceCmp;
  assign id_addr     = IdW'(id_ext);
  assign start_id    = ({1'b0, next_id_r} >= SpaceC) ? IdW'(WRAP_ID) : next_id_r;
  assign cur_adv     = adv_id(cur_r);
  assign seq_inc     = seq_r + SEQ_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      next_id_r   <= IdW'(1);
      seq_r       <= SEQ_W'(1);
      rsv_r       <= '0;
      reg_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      next_id_r   <= next_id_nxt;
      seq_r       <= seq_nxt;
      rsv_r       <= rsv_nxt;
      reg_r       <= reg_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r         <= act_nxt;
    cur_r         <= cur_nxt;
    cnt_r         <= cnt_nxt;
    rng_r         <= rng_nxt;
    res_status_r  <= res_status_nxt;
    res_id_r      <= res_id_nxt;
    res_seq_r     <= res_seq_nxt;
    res_present_r <= res_present_nxt;
    out_data_r    <= out_data_nxt;
  end

  always_comb begin
    state_nxt       = state_r;
    act_nxt         = act_r;
    cur_nxt         = cur_r;
    cnt_nxt         = cnt_r;
    rng_nxt         = rng_r;
    next_id_nxt     = next_id_r;
    seq_nxt         = seq_r;
    rsv_nxt         = rsv_r;
    reg_nxt         = reg_r;
    res_status_nxt  = res_status_r;
    res_id_nxt      = res_id_r;
    res_seq_nxt     = res_seq_r;
    res_present_nxt = res_present_r;
    out_valid_nxt   = out_valid_r && !out_tready;
    out_data_nxt    = out_data_r;
    map_rd_en       = 1'b0;
    map_rd_addr     = cur_r;
    map_wr_en       = 1'b0;
    map_wr_addr     = cur_r;
    map_wr_bit      = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          act_nxt         = act_t'(in_tuser);
          res_status_nxt  = STAT_OK;
          res_id_nxt      = '0;
          res_seq_nxt     = '0;
          res_present_nxt = 1'b0;
          state_nxt       = S_DONE;
          case (act_t'(in_tuser))
            ACT_RESERVE: begin
              if (rsv_r >= CNT_W'(SLOT_LIMIT)) begin
                res_status_nxt = STAT_NO_SLOT;
              end else begin
                rsv_nxt = rsv_r + CNT_W'(1);
              end
            end
            ACT_RELEASE: begin
              if (rsv_r == '0) begin
                res_status_nxt = STAT_UNDERFLOW;
              end else begin
                rsv_nxt = rsv_r - CNT_W'(1);
              end
            end
            ACT_ASSIGN: begin
              map_rd_en   = 1'b1;
              map_rd_addr = start_id;
              cur_nxt     = start_id;
              cnt_nxt     = '0;
              state_nxt   = S_PROBE;
            end
            ACT_REMOVE, ACT_LOOKUP: begin
              map_rd_en   = id_in_range;
              map_rd_addr = id_addr;
              cur_nxt     = id_addr;
              rng_nxt     = id_in_range;
              state_nxt   = S_PROBE;
            end
            default: begin
            end
          endcase
        end
      end

      S_PROBE: begin
        state_nxt = S_DONE;
        case (act_r)
          ACT_ASSIGN: begin
            if (!map_rd_bit) begin
              map_wr_en   = 1'b1;
              map_wr_addr = cur_r;
              map_wr_bit  = 1'b1;
              next_id_nxt = cur_adv;
              res_id_nxt  = ID_W'(cur_r);
              res_seq_nxt = seq_r;
              seq_nxt     = (seq_inc == '0) ? SEQ_W'(1) : seq_inc;
              reg_nxt     = reg_r + CNT_W'(1);
            end else if (cnt_r == IdW'(ID_SPACE - 1)) begin
              res_status_nxt = STAT_NO_FREE;
            end else begin
              cur_nxt     = cur_adv;
              cnt_nxt     = cnt_r + IdW'(1);
              map_rd_en   = 1'b1;
              map_rd_addr = cur_adv;
              state_nxt   = S_PROBE;
            end
          end
          ACT_REMOVE: begin
            if (rng_r && map_rd_bit) begin
              map_wr_en       = 1'b1;
              map_wr_addr     = cur_r;
              map_wr_bit      = 1'b0;
              reg_nxt         = reg_r - CNT_W'(1);
              res_present_nxt = 1'b1;
            end else begin
              res_status_nxt = STAT_NOT_FOUND;
            end
          end
          ACT_LOOKUP: begin
            res_present_nxt = rng_r && map_rd_bit;
          end
          default: begin
          end
        endcase
      end

      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {2'b00, res_present_r, res_seq_r, res_id_r, res_status_r};
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
